[rtl/core/smsp_pkg.sv]
// ----------------------------------------------------------------------------
// smsp_pkg
// Shared constants and types for the shuffled minimal-standard generator.
// ----------------------------------------------------------------------------
package smsp_pkg;

  localparam int unsigned WORD_W  = 32;   // generator word, two's complement
  localparam int unsigned VALUE_W = 31;   // table entries and results

  localparam logic [14:0]        LEHMER_MULT = 15'd16807;
  localparam logic [VALUE_W-1:0] LEHMER_MOD  = 31'h7fff_ffff;

  // one less than the warm-up steps before the table fill
  localparam int unsigned WARMUP_EXTRA = 7;

  localparam int unsigned DEF_TABLE_ENTRIES = 32;

  // function codes of an input word
  localparam logic FUNC_SEED = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT_MUL,
    ST_INIT_RED,
    ST_DRAW_MUL,
    ST_DRAW_RED,
    ST_DRAW_WR
  } state_t;

endpackage

[rtl/core/shuffled_minimal_standard_prng.sv]
// ----------------------------------------------------------------------------
// shuffled_minimal_standard_prng
// Park-Miller minimal-standard generator with a Bays-Durham shuffle table.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one word carries in_func and in_seed.
//   A seed word (func 0) loads the generator word with -|seed| and clears the
//   last output. It gives no result and leaves the block idle.
//   A draw word (func 1) gives exactly one out_random_value.
// A normal draw goes through these steps to the output register: the
// Lehmer multiply with the slot select, then the mod reduction with the table
// read, then the table write-back; no new word is taken until it is done.
// A draw that finds the generator word non-positive or the last output zero
// first rebuilds the table: TABLE_ENTRIES + 8 Lehmer steps, each a multiply
// state and a reduce state through the one multiplier, before the normal draw.
// Output channel (out_valid / out_stall): a result waits in the output
// register; seed words are still taken meanwhile, and a following draw
// holds in its write-back step until the register frees up.
// Reset clears the generator word and the last output, so the first draw
// always rebuilds the table; the table itself is not cleared.
// ----------------------------------------------------------------------------
module shuffled_minimal_standard_prng
  import smsp_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_func,
  input  logic signed [WORD_W-1:0] in_seed,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [VALUE_W-1:0]       out_random_value
);

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + WARMUP_EXTRA + 1);

  state_t             state_r, state_nxt;
  logic [WORD_W-1:0]  gw_r, gw_nxt;
  logic [VALUE_W-1:0] lo_r, lo_nxt;
  logic [WORD_W-1:0]  x_r, x_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [IW-1:0]      slot_r, slot_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;

  logic               mul_ld;
  logic [WORD_W-1:0]  mul_x;
  logic [VALUE_W-1:0] step_y;
  logic [IW-1:0]      slot_q;
  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic               ram_re;
  logic [VALUE_W-1:0] ram_rdata;
  logic               need_init;

  smsp_lehmer u_lehmer (
    .clk  (clk),
    .ld   (mul_ld),
    .x_in (mul_x),
    .y    (step_y)
  );

  smsp_slot #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_slot (
    .value (lo_r),
    .slot  (slot_q)
  );

  smsp_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  // generator word is two's complement; bit 31 is its sign
  assign need_init = gw_r[WORD_W-1] || (gw_r == '0) || (lo_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gw_r        <= '0;
      lo_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gw_r        <= gw_nxt;
      lo_r        <= lo_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    cnt_r       <= cnt_nxt;
    slot_r      <= slot_nxt;
    out_value_r <= out_value_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    gw_nxt        = gw_r;
    lo_nxt        = lo_r;
    x_nxt         = x_r;
    cnt_nxt       = cnt_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    mul_ld        = 1'b0;
    mul_x         = x_r;
    ram_we        = 1'b0;
    ram_waddr     = slot_r;
    ram_wdata     = step_y;
    ram_re        = 1'b0;
    in_stall      = (state_r != ST_IDLE);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_func == FUNC_SEED) begin
            gw_nxt = in_seed[WORD_W-1] ? in_seed : (~in_seed + WORD_W'(1));
            lo_nxt = '0;
          end else if (need_init) begin
            // magnitude of a negative word, otherwise forced to one
            x_nxt     = gw_r[WORD_W-1] ? (~gw_r + WORD_W'(1)) : WORD_W'(1);
            cnt_nxt   = CW'(TABLE_ENTRIES + WARMUP_EXTRA);
            state_nxt = ST_INIT_MUL;
          end else begin
            mul_ld    = 1'b1;
            mul_x     = gw_r;
            slot_nxt  = slot_q;
            state_nxt = ST_DRAW_RED;
          end
        end
      end
      ST_INIT_MUL: begin
        mul_ld    = 1'b1;
        mul_x     = x_r;
        state_nxt = ST_INIT_RED;
      end
      ST_INIT_RED: begin
        x_nxt = WORD_W'(step_y);
        // table fills from the top slot down during the last steps
        if (cnt_r < CW'(TABLE_ENTRIES)) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_r[IW-1:0];
          ram_wdata = step_y;
        end
        if (cnt_r == '0) begin
          gw_nxt    = WORD_W'(step_y);
          lo_nxt    = step_y;
          state_nxt = ST_DRAW_MUL;
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = ST_INIT_MUL;
        end
      end
      ST_DRAW_MUL: begin
        mul_ld    = 1'b1;
        mul_x     = gw_r;
        slot_nxt  = slot_q;
        state_nxt = ST_DRAW_RED;
      end
      ST_DRAW_RED: begin
        gw_nxt    = WORD_W'(step_y);
        ram_re    = 1'b1;
        state_nxt = ST_DRAW_WR;
      end
      ST_DRAW_WR: begin
        // read data holds while the output register is still full
        if (!out_valid_r || !out_stall) begin
          lo_nxt        = ram_rdata;
          out_value_nxt = ram_rdata;
          out_valid_nxt = 1'b1;
          ram_we        = 1'b1;
          ram_waddr     = slot_r;
          ram_wdata     = gw_r[VALUE_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_random_value = out_value_r;

endmodule

[rtl/core/smsp_ram.sv]
// ----------------------------------------------------------------------------
// smsp_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module smsp_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/smsp_lehmer.sv]
// ----------------------------------------------------------------------------
// smsp_lehmer
// Two-stage Lehmer step: registered product by 16807, then reduction
// modulo 2^31-1 by folding the high part onto the low part.
// ----------------------------------------------------------------------------
module smsp_lehmer
  import smsp_pkg::*;
(
  input  logic               clk,
  input  logic               ld,
  input  logic [WORD_W-1:0]  x_in,
  output logic [VALUE_W-1:0] y
);

  localparam int unsigned PROD_W = WORD_W + 15;

  logic [PROD_W-1:0] prod_r;
  logic [WORD_W-1:0] fold;

  always_ff @(posedge clk) begin
    if (ld) begin
      prod_r <= PROD_W'(x_in) * PROD_W'(LEHMER_MULT);
    end
  end

  // 2^31 == 1 mod (2^31-1), so hi + lo is congruent and below twice the modulus
  assign fold = WORD_W'(prod_r[PROD_W-1:VALUE_W]) + WORD_W'(prod_r[VALUE_W-1:0]);

  always_comb begin
    if (fold >= WORD_W'(LEHMER_MOD)) begin
      y = VALUE_W'(fold - WORD_W'(LEHMER_MOD));
    end else begin
      y = VALUE_W'(fold);
    end
  end

endmodule

[rtl/core/smsp_slot.sv]
// ----------------------------------------------------------------------------
// smsp_slot
// Shuffle slot select: last output divided by the slot width, by a
// reciprocal multiply, saturated to the top slot.
// ----------------------------------------------------------------------------
module smsp_slot
  import smsp_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic [VALUE_W-1:0]               value,
  output logic [$clog2(TABLE_ENTRIES)-1:0] slot
);

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam logic [63:0] SLOT_DIV =
    64'd1 + (64'(LEHMER_MOD) - 64'd1) / 64'(TABLE_ENTRIES);
  localparam int unsigned SHIFT_L = $clog2(SLOT_DIV);
  // exact for every 31-bit dividend, fits in 32 bits
  localparam logic [63:0] MAGIC =
    ((64'd1 << (VALUE_W + SHIFT_L)) + SLOT_DIV - 64'd1) / SLOT_DIV;
  localparam int unsigned PW = VALUE_W + 32;
  localparam int unsigned QW = PW - (VALUE_W + SHIFT_L);

  logic [PW-1:0] prod;
  logic [QW-1:0] quo;

  assign prod = PW'(value) * PW'(MAGIC[31:0]);
  assign quo  = prod[PW-1:VALUE_W+SHIFT_L];

  always_comb begin
    if (quo >= QW'(TABLE_ENTRIES)) begin
      slot = IW'(TABLE_ENTRIES - 1);
    end else begin
      slot = quo[IW-1:0];
    end
  end

endmodule

[rtl/core/smsp_checker.sv]
// ----------------------------------------------------------------------------
// smsp_checker
// Port-level checks on the shuffled generator, bound to the top level.
// ----------------------------------------------------------------------------
module smsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_func,
  input logic        out_valid,
  input logic        out_stall,
  input logic [30:0] out_random_value
);

  // a waiting result holds its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_random_value))
    else $error("stalled result changed or dropped");

  // results never reach the modulus
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_random_value != 31'h7fff_ffff)
    else $error("result out of range");

  // an accepted draw keeps the block busy, a seed load does not
  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> (in_stall == $past(in_func)))
    else $error("busy state does not follow the accepted word");

  // a result only appears out of a busy cycle
  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a draw in progress");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind shuffled_minimal_standard_prng smsp_checker u_smsp_checker (.*);

[dv/shuffled_minimal_standard_prng_test.sv]
// ----------------------------------------------------------------------------
// shuffled_minimal_standard_prng_test
// Self-checking bench for the shuffled minimal-standard generator. A local
// model of the Lehmer recurrence and the shuffle table predicts every drawn
// value, and a checker compares each output word with the oldest prediction.
// Reset draws, corner seeds, then random seed/draw traffic with idle bursts on
// both channels, a long output hold-off, a sender pause, and a streaming tail.
// ----------------------------------------------------------------------------
module shuffled_minimal_standard_prng_test;
  import smsp_pkg::*;

  localparam int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES;
  localparam longint SCHRAGE_Q = 127773;
  localparam longint SCHRAGE_R = 2836;
  localparam longint MOD_VALUE = longint'(LEHMER_MOD);
  localparam longint SLOT_DIV  = 1 + (MOD_VALUE - 1) / TABLE_ENTRIES;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 200;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_func;
  logic signed [WORD_W-1:0] in_seed;
  logic                     out_valid;
  logic                     out_stall;
  logic [VALUE_W-1:0]       out_random_value;

  // model state
  longint             gen_word;
  logic [VALUE_W-1:0] prev_value;
  logic [VALUE_W-1:0] shuffle_tab [TABLE_ENTRIES];

  logic [VALUE_W-1:0] value_q [$];
  logic [VALUE_W-1:0] want_value;
  int unsigned        failures;
  int unsigned        quiet_cycles;
  bit                 tx_idle_en;
  bit                 rx_idle_en;
  bit                 hold_request;

  shuffled_minimal_standard_prng #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_seed         (in_seed),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_random_value(out_random_value)
  );

  always #4 clk = ~clk;

  function automatic longint lehmer_next(input longint x);
    longint hi;
    longint y;
    hi = x / SCHRAGE_Q;
    y = longint'(LEHMER_MULT) * (x - hi * SCHRAGE_Q) - SCHRAGE_R * hi;
    if (y < 0) begin
      y += MOD_VALUE;
    end
    return y;
  endfunction

  function automatic void load_seed(input logic signed [WORD_W-1:0] seed);
    longint s;
    s = longint'(seed);
    gen_word = (s < 0) ? s : -s;
    prev_value = '0;
  endfunction

  function automatic logic [VALUE_W-1:0] predict_draw();
    longint w;
    longint slot;
    int j;
    if (gen_word <= 0 || prev_value == 0) begin
      // rebuild: magnitude of the word, then warm-up and table fill top-down
      w = -gen_word;
      if (w < 1) begin
        w = 1;
      end
      for (j = int'(TABLE_ENTRIES + WARMUP_EXTRA); j >= 0; j--) begin
        w = lehmer_next(w);
        if (j < int'(TABLE_ENTRIES)) begin
          shuffle_tab[j] = w[VALUE_W-1:0];
        end
      end
      gen_word = w;
      prev_value = shuffle_tab[0];
    end
    gen_word = lehmer_next(gen_word);
    slot = longint'(prev_value) / SLOT_DIV;
    if (slot >= TABLE_ENTRIES) begin
      slot = TABLE_ENTRIES - 1;
    end
    prev_value = shuffle_tab[slot];
    shuffle_tab[slot] = gen_word[VALUE_W-1:0];
    return prev_value;
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_seed();
    logic signed [WORD_W-1:0] s;
    case ($urandom_range(0, 9))
      0: s = 32'sh8000_0000;
      1: s = 32'sh7fff_ffff;
      2: s = 32'sh8000_0001;
      3: s = '0;
      4: s = $urandom_range(1, 20);
      5: s = -$signed({1'b0, 31'($urandom_range(1, 20))});
      default: s = $urandom;
    endcase
    return s;
  endfunction

  // one word on the input channel; the model is updated at acceptance
  task automatic send_word(input logic func, input logic signed [WORD_W-1:0] seed);
    in_valid <= 1'b1;
    in_func  <= func;
    in_seed  <= seed;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (func == FUNC_SEED) begin
      load_seed(seed);
    end else begin
      value_q.push_back(predict_draw());
    end
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      in_func  <= 1'($urandom);
      in_seed  <= $urandom;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (value_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_draws_after_reset();
    int i;
    for (i = 0; i < 3; i++) begin
      send_word(FUNC_DRAW, $urandom);
    end
  endtask

  task automatic test_seed_corners();
    int k;
    logic signed [WORD_W-1:0] s;
    for (k = 0; k < 7; k++) begin
      case (k)
        0: s = '0;
        1: s = 32'sd1;
        2: s = -32'sd1;
        3: s = 32'sh7fff_ffff;   // equals the modulus, walks into zero words
        4: s = -32'sh7fff_ffff;
        5: s = 32'sh8000_0000;
        default: s = 32'sd16807;
      endcase
      send_word(FUNC_SEED, s);
      send_word(FUNC_DRAW, ~s);
      send_word(FUNC_DRAW, s);
    end
    // back-to-back seeds, only the second one counts
    send_word(FUNC_SEED, 32'sd12345);
    send_word(FUNC_SEED, 32'sh8000_0000);
    send_word(FUNC_DRAW, '0);
  endtask

  task automatic test_random_mix(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(FUNC_SEED, pick_seed());
      end else begin
        send_word(FUNC_DRAW, $urandom);
      end
    end
  endtask

  task automatic test_output_hold();
    int i;
    tx_idle_en = 1'b0;
    hold_request = 1'b1;
    for (i = 0; i < 16; i++) begin
      send_word(FUNC_DRAW, $urandom);
    end
    tx_idle_en = 1'b1;
  endtask

  task automatic test_sender_pause();
    int i;
    for (i = 0; i < 8; i++) begin
      send_word(FUNC_DRAW, $urandom);
    end
    wait_drained();
    send_word(FUNC_SEED, pick_seed());
    for (i = 0; i < 8; i++) begin
      send_word(FUNC_DRAW, $urandom);
    end
  endtask

  // receiver: random stall bursts and the long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (value_q.size() == 0) begin
        $error("random_value: expected none, actual %0d", out_random_value);
        failures++;
      end else begin
        want_value = value_q.pop_front();
        if (out_random_value !== want_value) begin
          $error("random_value: expected %0d, actual %0d", want_value, out_random_value);
          failures++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_SEED;
    in_seed = '0;
    out_stall = 1'b0;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_request = 1'b0;
    failures = 0;
    quiet_cycles = 0;
    gen_word = 0;
    prev_value = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_draws_after_reset();
    test_seed_corners();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_random_mix(1300);
    test_output_hold();
    test_sender_pause();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_mix(350);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
